// File: rtl/sle_pkg.sv
// Package for the sorted list engine: sizes, command and status codes,
// queue entry type and back-end state type. No dependencies.
`default_nettype none
package sle_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY,
    S_DUMP
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [DATA_W-1:0] value;
  } op_t;

endpackage
`default_nettype wire

// File: rtl/sle_front.sv
// Front end: accepts command beats, drops unused codes and queues the rest.
// Depends on sle_pkg.
`default_nettype none
module sle_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       command_i,
  input  wire logic signed [sle_pkg::DATA_W-1:0] value_i,
  output logic                                  q_valid_o,
  output sle_pkg::op_t                          q_op_o,
  input  wire logic                             q_pop_i
);
  import sle_pkg::*;

  op_t                 slot_q [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   fill_q;
  logic                known_cmd;
  logic                push;
  logic                pop;

  always_comb begin
    case (command_i)
      CMD_INSERT, CMD_DELETE, CMD_DUMP: known_cmd = 1'b1;
      default:                          known_cmd = 1'b0;
    endcase
  end

  assign in_stall_o = (fill_q == QCNT_W'(Q_DEPTH));
  assign push       = in_valid_i && !in_stall_o && known_cmd;
  assign q_valid_o  = (fill_q != '0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_op_o     = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= '{cmd: cmd_e'(command_i), value: value_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/sle_back.sv
// Back end: row of sorted cells with per-cell compare, shift sequencer,
// dump streaming and the output register. Depends on sle_pkg.
`default_nettype none
module sle_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_valid_i,
  input  wire sle_pkg::op_t                     q_op_i,
  output logic                                  q_pop_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic signed [sle_pkg::DATA_W-1:0]     item_o,
  output logic [1:0]                            status_o,
  output logic                                  last_o
);
  import sle_pkg::*;

  state_e                    state_q, state_d;
  op_t                       op_q;
  logic signed [DATA_W-1:0]  cell_q [CAPACITY];
  logic signed [DATA_W-1:0]  cell_ins [CAPACITY];
  logic signed [DATA_W-1:0]  cell_del [CAPACITY];
  logic [CAPACITY-1:0]       lt_q, lt_d, hit;
  logic                      found_q;
  logic [CNT_W-1:0]          count_q;
  logic [IDX_W-1:0]          idx_q;

  logic                      out_valid_q;
  logic signed [DATA_W-1:0]  item_q, item_d;
  status_e                   status_q, status_d;
  logic                      last_q, last_d;

  logic                      slot_free;
  logic                      out_load;
  logic                      cmp_en, ins_en, del_en;
  logic                      idx_clr, idx_inc;
  logic                      dump_last;

  // Per-cell compare and shift candidates; lt is monotone over a sorted row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic valid_c;
    logic prev_lt_d;
    assign valid_c = (CNT_W'(g) < count_q);
    assign lt_d[g] = valid_c && (cell_q[g] < op_q.value);
    if (g == 0) begin : g_first
      assign prev_lt_d   = 1'b1;
      assign cell_ins[g] = lt_q[g] ? cell_q[g] : op_q.value;
    end else begin : g_rest
      assign prev_lt_d   = lt_d[g-1];
      assign cell_ins[g] = lt_q[g] ? cell_q[g] : (lt_q[g-1] ? op_q.value : cell_q[g-1]);
    end
    if (g == CAPACITY - 1) begin : g_top
      assign cell_del[g] = cell_q[g];
    end else begin : g_below
      assign cell_del[g] = lt_q[g] ? cell_q[g] : cell_q[g+1];
    end
    assign hit[g] = valid_c && !lt_d[g] && prev_lt_d && (cell_q[g] == op_q.value);
  end

  assign slot_free = !out_valid_q || !out_stall_i;
  assign dump_last = ({1'b0, idx_q} + 1'b1) == count_q;

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    cmp_en   = 1'b0;
    ins_en   = 1'b0;
    del_en   = 1'b0;
    idx_clr  = 1'b0;
    idx_inc  = 1'b0;
    out_load = 1'b0;
    item_d   = op_q.value;
    status_d = ST_OK;
    last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmp_en  = 1'b1;
        state_d = S_APPLY;
      end
      S_APPLY: begin
        if (op_q.cmd == CMD_DUMP) begin
          if (count_q == '0) begin
            item_d   = '0;
            status_d = ST_EMPTY;
            if (slot_free) begin
              out_load = 1'b1;
              state_d  = S_IDLE;
            end
          end else begin
            idx_clr = 1'b1;
            state_d = S_DUMP;
          end
        end else if (slot_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
          if (op_q.cmd == CMD_INSERT) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              ins_en = 1'b1;
            end
          end else begin
            if (found_q) begin
              del_en = 1'b1;
            end else begin
              status_d = ST_NOTFOUND;
            end
          end
        end
      end
      S_DUMP: begin
        item_d = cell_q[idx_q];
        last_d = dump_last;
        if (slot_free) begin
          out_load = 1'b1;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            idx_inc = 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ins_en) begin
        count_q <= count_q + 1'b1;
      end else if (del_en) begin
        count_q <= count_q - 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      op_q <= q_op_i;
    end
    if (cmp_en) begin
      lt_q    <= lt_d;
      found_q <= |hit;
    end
    for (int i = 0; i < CAPACITY; i++) begin
      if (ins_en) begin
        cell_q[i] <= cell_ins[i];
      end else if (del_en) begin
        cell_q[i] <= cell_del[i];
      end
    end
    if (idx_clr) begin
      idx_q <= '0;
    end else if (idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
    if (out_load) begin
      item_q   <= item_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign item_o      = item_q;
  assign status_o    = status_q;
  assign last_o      = last_q;

endmodule
`default_nettype wire

// File: rtl/sorted_list_engine_top.sv
// Top level of the sorted list engine: front queue feeding the cell back end.
// Depends on sle_pkg, sle_front and sle_back.
//
// Keeps up to 32 signed values in ascending order. Command 0 inserts, 1
// deletes the first equal entry, 2 dumps all entries in order with last set
// on the final beat; code 3 is accepted and discarded. A two-entry command
// queue takes beats while the back end works. Insert and delete pass through
// three back-end steps (queue pop, parallel compare across every cell, shift
// of the cell row); a dump pops and compares likewise, then streams the stored
// entries, one per beat, through the single read port that reads the cells. A busy
// output slot holds the back end until the result beat is taken.
`default_nettype none
module sorted_list_engine_top (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [1:0]                        command_i,
  input  wire logic signed [sle_pkg::DATA_W-1:0] value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic signed [sle_pkg::DATA_W-1:0]      item_o,
  output logic [1:0]                             status_o,
  output logic                                   last_o
);
  import sle_pkg::*;

  logic q_valid;
  op_t  q_op;
  logic q_pop;

  sle_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .value_i    (value_i),
    .q_valid_o  (q_valid),
    .q_op_o     (q_op),
    .q_pop_i    (q_pop)
  );

  sle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (item_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// File: rtl/sle_checker.sv
// Port-level checks for the sorted list engine, bound to the top level.
// Depends on sle_pkg and sorted_list_engine_top.
`default_nettype none
module sle_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              out_valid_o,
  input wire logic                              out_stall_i,
  input wire logic signed [sle_pkg::DATA_W-1:0] item_o,
  input wire logic [1:0]                        status_o,
  input wire logic                              last_o
);
  import sle_pkg::*;

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(item_o) &&
    $stable(status_o) && $stable(last_o))
    else $error("stalled result beat changed");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (item_o == '0) && last_o)
    else $error("empty dump beat malformed");

  // only dump beats before the final one lack last, and those are always ok
  a_mid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> (status_o == ST_OK))
    else $error("non-final beat with error status");

  // a dump stream continues as ok beats until its last
  a_dump_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o ##1 out_valid_o |-> (status_o == ST_OK))
    else $error("dump stream interrupted by another result");

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .item_o      (item_o),
  .status_o    (status_o),
  .last_o      (last_o)
);
`default_nettype wire

// File: bench/sorted_list_engine_top_tb.sv
// Self-checking bench for sorted_list_engine_top: a shadow sorted list predicts every result
// beat, and random stalls and gaps are applied on both handshake sides.
// Depends on sle_pkg and sorted_list_engine_top.
`timescale 1ns / 100ps
module sorted_list_engine_top_tb;
  import sle_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int unsigned RANDOM_ITEMS = 200;
  localparam int unsigned SETTLE_CYCLES = 50;

  typedef struct {
    logic signed [DATA_W-1:0] item;
    status_e                  status;
    logic                     last;
  } result_beat_t;

  class sorted_store_tracker;
    logic signed [DATA_W-1:0] shadow_list[$];
    result_beat_t             expected_beats[$];
    int unsigned              mismatches;

    function void push_beat(logic signed [DATA_W-1:0] item, status_e status, logic last);
      result_beat_t b;
      b.item = item;
      b.status = status;
      b.last = last;
      expected_beats.push_back(b);
    endfunction

    // Update the shadow list for an accepted command and queue its result beats.
    function void note_command(logic [1:0] cmd, logic signed [DATA_W-1:0] val);
      int pos;
      case (cmd)
        CMD_INSERT: begin
          if (shadow_list.size() >= CAPACITY) begin
            push_beat(val, ST_FULL, 1'b1);
          end else begin
            pos = 0;
            while (pos < shadow_list.size() && shadow_list[pos] < val) pos++;
            shadow_list.insert(pos, val);
            push_beat(val, ST_OK, 1'b1);
          end
        end
        CMD_DELETE: begin
          pos = 0;
          while (pos < shadow_list.size() && shadow_list[pos] != val) pos++;
          if (pos >= shadow_list.size()) begin
            push_beat(val, ST_NOTFOUND, 1'b1);
          end else begin
            shadow_list.delete(pos);
            push_beat(val, ST_OK, 1'b1);
          end
        end
        CMD_DUMP: begin
          if (shadow_list.size() == 0) begin
            push_beat('0, ST_EMPTY, 1'b1);
          end else begin
            foreach (shadow_list[i])
              push_beat(shadow_list[i], ST_OK, i == shadow_list.size() - 1);
          end
        end
        default: ;  // unused code: dropped, no result
      endcase
    endfunction

    function void check_beat(logic signed [DATA_W-1:0] item, logic [1:0] status, logic last);
      result_beat_t want;
      if (expected_beats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat item=%0d status=%0d last=%0d",
                   $time, item, status, last);
      end else begin
        want = expected_beats.pop_front();
        if (item !== want.item || status !== want.status || last !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: beat mismatch: expected item=%0d status=%0d last=%0d, got item=%0d status=%0d last=%0d",
                     $time, want.item, want.status, want.last, item, status, last);
        end
      end
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function int stored();
      return shadow_list.size();
    endfunction

    function logic signed [DATA_W-1:0] pick_stored();
      return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               command_i;
  logic signed [DATA_W-1:0] value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [DATA_W-1:0] item_o;
  logic [1:0]               status_o;
  logic                     last_o;

  sorted_store_tracker tracker = new();
  int unsigned items_sent;
  bit          fast_in;
  bit          fast_out;

  sorted_list_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .item_o      (item_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Note accepted commands before checking beats taken on the same edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) tracker.note_command(command_i, value_i);
    if (rst_ni && out_valid_o && !out_stall_i) tracker.check_beat(item_o, status_o, last_o);
  end

  // Receiver: random stalls, stall-free stretches, and a long hold now and then.
  initial begin
    int unsigned beats_taken;
    int unsigned gap;
    beats_taken = 0;
    fast_out = 1'b0;
    out_stall_i <= 1'b1;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (beats_taken % 64 == 0) fast_out = ($urandom_range(0, 2) == 0);
      gap = fast_out ? 0 : $urandom_range(0, 3);
      if (beats_taken % 150 == 90) gap = 120;
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      beats_taken++;
    end
  end

  task automatic send_beat(input logic [1:0] cmd, input logic signed [DATA_W-1:0] val);
    int unsigned gap;
    gap = fast_in ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  // Hold off new commands until every queued beat has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic signed [DATA_W-1:0] rand_value();
    int unsigned r;
    r = $urandom_range(0, 5);
    case (r)
      0, 1: return $signed($urandom_range(0, 15)) - 8;
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [DATA_W-1:0] delete_value();
    if (tracker.stored() != 0 && $urandom_range(0, 4) != 0) return tracker.pick_stored();
    return rand_value();
  endfunction

  initial begin
    int unsigned episode;
    int unsigned n;
    int unsigned r;
    in_valid_i  <= 1'b0;
    command_i   <= CMD_INSERT;
    value_i     <= '0;
    items_sent  = 0;
    fast_in     = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty dump, absent delete, extremes, duplicates, unused code.
    send_beat(CMD_DUMP, 32'sd77);
    send_beat(CMD_DELETE, 32'sd7);
    send_beat(CMD_INSERT, 32'sd0);
    send_beat(CMD_INSERT, VAL_MAX);
    send_beat(CMD_INSERT, VAL_MIN);
    send_beat(CMD_INSERT, -32'sd1);
    send_beat(CMD_INSERT, 32'sd1);
    send_beat(CMD_INSERT, 32'sd5);
    send_beat(CMD_INSERT, 32'sd5);
    send_beat(CMD_INSERT, 32'sh5555_5555);
    send_beat(CMD_INSERT, 32'shaaaa_aaaa);
    send_beat(CMD_UNUSED, 32'sd123);
    send_beat(CMD_DUMP, 32'sd0);
    send_beat(CMD_DELETE, 32'sd5);
    send_beat(CMD_DELETE, 32'sd99);
    send_beat(CMD_DELETE, VAL_MIN);
    send_beat(CMD_DELETE, VAL_MAX);
    send_beat(CMD_DUMP, -32'sd1);
    items_sent = 0;

    episode = 0;
    while (items_sent < RANDOM_ITEMS) begin
      fast_in = ($urandom_range(0, 3) == 0);
      r = (episode == 0) ? 0 : $urandom_range(0, 5);
      case (r)
        0, 1: begin
          // fill to capacity and overflow
          n = CAPACITY - tracker.stored() + $urandom_range(1, 4);
          repeat (n) send_beat(CMD_INSERT, rand_value());
          send_beat(CMD_DUMP, rand_value());
        end
        2, 3: begin
          n = $urandom_range(3, 40);
          repeat (n) send_beat(CMD_DELETE, delete_value());
          send_beat(CMD_DUMP, rand_value());
        end
        default: begin
          repeat (15) begin
            r = $urandom_range(0, 99);
            if (r < 40)      send_beat(CMD_INSERT, rand_value());
            else if (r < 70) send_beat(CMD_DELETE, delete_value());
            else if (r < 92) send_beat(CMD_DUMP, rand_value());
            else             send_beat(CMD_UNUSED, rand_value());
          end
        end
      endcase
      if (episode == 0 || $urandom_range(0, 4) == 0) wait_drained();
      episode++;
    end

    wait_drained();
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
